/* hdl/rs485_telegram_receiver_assert.svh */
// Assertion macros shared by the telegram receiver RTL.
`ifndef RS485_TELEGRAM_RECEIVER_ASSERT_SVH
`define RS485_TELEGRAM_RECEIVER_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define RTR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define RTR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/rs485_tr_pkg.sv */
// Types and constants for the telegram receiver.
`timescale 1ns / 1ps
`default_nettype none

package rs485_tr_pkg;

	localparam logic [7:0] START_BYTE = 8'h00;
	localparam logic [7:0] END_BYTE = 8'hFF;

	localparam logic [2:0] POS_SENDER = 3'd1;
	localparam logic [2:0] POS_DEST = 3'd2;
	localparam logic [2:0] POS_COMMAND = 3'd3;
	localparam logic [2:0] POS_PAYLOAD = 3'd4;
	localparam logic [2:0] POS_CHECKSUM = 3'd5;
	localparam logic [2:0] POS_END = 3'd6;

	typedef enum logic [1:0] {
		STAT_OK = 2'd0,
		STAT_BAD_END = 2'd1,
		STAT_BAD_SUM = 2'd2,
		STAT_NOT_OURS = 2'd3
	} frame_status_t;

	typedef struct packed {
		frame_status_t status;
		logic [7:0] sender;
		logic [7:0] command;
		logic [7:0] payload;
	} result_t;

endpackage

`default_nettype wire

/* hdl/rs485_telegram_receiver.sv */
// Top level of the telegram receiver: input stage, framer, result register.
//
//  channel | direction | handshake          | payload
//  in      | in        | in_valid/in_stall   | rx_byte
//  out     | out       | out_valid/out_stall | frame_status, sender_addr, command_code, payload_byte
//  cfg     | in        | cfg_we              | cfg_wdata (own_address)
//
// One byte per cycle sustained unless in_stall is raised; a byte passes the input register
// and the framer, and its result, if any, is registered in the result register.
// Reset clears framing state, own_address and both valid flags; no clearing pass.
// A result held under out_stall stalls the input only when the next byte ends a frame.
`timescale 1ns / 1ps
`default_nettype none

`include "rs485_telegram_receiver_assert.svh"

module rs485_telegram_receiver (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [7:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] rx_byte,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] frame_status,
	output logic [7:0] sender_addr,
	output logic [7:0] command_code,
	output logic [7:0] payload_byte
);

	logic valid_s1;
	logic [7:0] rx_byte_s1;
	logic advance;
	logic emit;
	logic in_accept;
	rs485_tr_pkg::result_t result;
	logic out_valid_q;
	rs485_tr_pkg::result_t out_q;

	assign advance = valid_s1 && (!emit || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	rs485_tr_frame u_frame (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.step(advance),
		.rx_byte_s1(rx_byte_s1),
		.emit(emit),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_status = out_q.status;
	assign sender_addr = out_q.sender;
	assign command_code = out_q.command;
	assign payload_byte = out_q.payload;

	`RTR_ASSERT_ALWAYS(a_stall_cause, clk, in_stall |-> (valid_s1 && emit && out_valid_q && out_stall), "input stalled without a blocked result")
	`RTR_ASSERT(a_no_overwrite, clk, arst_n, (out_valid_q && out_stall) |-> !(advance && emit), "held result overwritten")

endmodule

`default_nettype wire

/* hdl/rs485_tr_frame.sv */
// Telegram framing state, field capture, checksum and result build.
`timescale 1ns / 1ps
`default_nettype none

`include "rs485_telegram_receiver_assert.svh"

module rs485_tr_frame (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [7:0] cfg_wdata,
	input wire logic step,
	input wire logic [7:0] rx_byte_s1,
	output logic emit,
	output rs485_tr_pkg::result_t result
);

	logic own_unused;
	logic [7:0] own_address_q;
	logic in_frame_q;
	logic [2:0] pos_q;
	logic [7:0] sum_q;
	logic [7:0] sender_q;
	logic [7:0] dest_q;
	logic [7:0] command_q;
	logic [7:0] payload_q;
	logic [7:0] checksum_q;
	logic is_start;
	logic [7:0] total;
	rs485_tr_pkg::frame_status_t status;

	assign own_unused = 1'b0;
	assign is_start = (rx_byte_s1 == rs485_tr_pkg::START_BYTE);
	assign emit = in_frame_q && !is_start && (pos_q == rs485_tr_pkg::POS_END) && !own_unused;
	assign total = sum_q + rx_byte_s1;

	always_comb begin
		if (rx_byte_s1 != rs485_tr_pkg::END_BYTE) begin
			status = rs485_tr_pkg::STAT_BAD_END;
		end else if (total != checksum_q) begin
			status = rs485_tr_pkg::STAT_BAD_SUM;
		end else if (dest_q != own_address_q) begin
			status = rs485_tr_pkg::STAT_NOT_OURS;
		end else begin
			status = rs485_tr_pkg::STAT_OK;
		end
		result.status = status;
		result.sender = sender_q;
		result.command = (status == rs485_tr_pkg::STAT_OK) ? command_q : 8'h00;
		result.payload = (status == rs485_tr_pkg::STAT_OK) ? payload_q : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= 8'h00;
		end else if (cfg_we) begin
			own_address_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q <= 3'd0;
			sum_q <= 8'h00;
		end else if (step) begin
			if (is_start) begin
				in_frame_q <= 1'b1;
				pos_q <= rs485_tr_pkg::POS_SENDER;
				sum_q <= 8'h00;
			end else if (in_frame_q) begin
				if (pos_q == rs485_tr_pkg::POS_END) begin
					in_frame_q <= 1'b0;
					pos_q <= 3'd0;
					sum_q <= 8'h00;
				end else begin
					if (pos_q != rs485_tr_pkg::POS_CHECKSUM) begin
						sum_q <= sum_q + rx_byte_s1;
					end
					pos_q <= pos_q + 3'd1;
				end
			end
		end
	end

	// capture fields by position
	always_ff @(posedge clk) begin
		if (step && in_frame_q && !is_start) begin
			case (pos_q)
				rs485_tr_pkg::POS_SENDER: sender_q <= rx_byte_s1;
				rs485_tr_pkg::POS_DEST: dest_q <= rx_byte_s1;
				rs485_tr_pkg::POS_COMMAND: command_q <= rx_byte_s1;
				rs485_tr_pkg::POS_PAYLOAD: payload_q <= rx_byte_s1;
				rs485_tr_pkg::POS_CHECKSUM: checksum_q <= rx_byte_s1;
				default: ;
			endcase
		end
	end

	`RTR_ASSERT_ALWAYS(a_hunt_clear, clk, !in_frame_q |-> (pos_q == 3'd0 && sum_q == 8'h00), "hunting with stale position or sum")
	`RTR_ASSERT_ALWAYS(a_pos_range, clk, in_frame_q |-> (pos_q != 3'd0 && pos_q != 3'd7), "frame position out of range")
	`RTR_ASSERT(a_emit_ends, clk, arst_n, (step && emit) |=> !in_frame_q, "frame not closed after result")

endmodule

`default_nettype wire
